/* rtl/core/bmpse_pkg.sv */
package bmpse_pkg;

    localparam int unsigned DATA_W        = 8;
    localparam int unsigned POS_W         = 32;
    localparam int unsigned LEN_BITS      = 10;
    localparam int unsigned SLOT_W        = 4;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [POS_W-1:0] HDR_OFF_FIRST = 32'd10;
    localparam logic [POS_W-1:0] HDR_OFF_LAST  = 32'd13;
    localparam logic [POS_W-1:0] HDR_END       = 32'd14;
    localparam logic [POS_W:0]   TRAILER_SPAN  = 33'd11;
    localparam logic [POS_W:0]   TRAILER_LAST  = 33'd10;
    localparam logic [POS_W-1:0] FILE_SIZE_RST = 32'd54;

    localparam logic [3:0] CHAR_BITS = 4'd8;
    localparam logic [3:0] STEP_ONE  = 4'd1;
    localparam logic [3:0] STEP_TWO  = 4'd2;

    typedef enum logic [0:0] {
        KIND_MSG   = 1'b0,
        KIND_COVER = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        MODE_ONE_BIT = 1'b0,
        MODE_TWO_BIT = 1'b1
    } mode_t;

    typedef enum logic [0:0] {
        REG_MODE      = 1'b0,
        REG_FILE_SIZE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              is_msg;
        logic [DATA_W-1:0] data;
        logic              trailer;
        logic [SLOT_W-1:0] slot;
        logic              embed;
        logic              last;
    } entry_t;

endpackage

/* rtl/core/bmpse_front.sv */
module bmpse_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [bmpse_pkg::DATA_W-1:0]      data,
    input  logic [bmpse_pkg::POS_W-1:0]       file_size,
    output logic                              push,
    output bmpse_pkg::entry_t                 push_entry,
    input  logic                              q_full
);

    logic [bmpse_pkg::POS_W-1:0] pos_reg;
    logic [bmpse_pkg::POS_W-1:0] pos_next;
    logic [bmpse_pkg::POS_W-1:0] offset_reg;
    logic [bmpse_pkg::POS_W-1:0] offset_next;
    logic [bmpse_pkg::POS_W:0]   slot_dist;
    logic [1:0]                  lane;
    logic                        is_cover;
    logic                        last;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign is_cover = (bmpse_pkg::kind_t'(kind) == bmpse_pkg::KIND_COVER);

    always_comb
    begin
        slot_dist = {1'b0, pos_reg} + bmpse_pkg::TRAILER_SPAN - {1'b0, file_size};
        last      = ({1'b0, pos_reg} + 33'd1) == {1'b0, file_size};
        lane      = pos_reg[1:0] - 2'd2;

        push_entry.is_msg  = !is_cover;
        push_entry.data    = data;
        push_entry.trailer = slot_dist <= bmpse_pkg::TRAILER_LAST;
        push_entry.slot    = slot_dist[bmpse_pkg::SLOT_W-1:0];
        push_entry.embed   = (pos_reg >= bmpse_pkg::HDR_END) && (pos_reg >= offset_reg);
        push_entry.last    = last;

        pos_next    = pos_reg;
        offset_next = offset_reg;
        if (push && is_cover)
        begin
            if (pos_reg >= bmpse_pkg::HDR_OFF_FIRST && pos_reg <= bmpse_pkg::HDR_OFF_LAST)
            begin
                case (lane)
                    2'd0:    offset_next[7:0]   = data;
                    2'd1:    offset_next[15:8]  = data;
                    2'd2:    offset_next[23:16] = data;
                    default: offset_next[31:24] = data;
                endcase
            end
            if (last)
            begin
                pos_next    = '0;
                offset_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
        end
    end

endmodule

/* rtl/core/bmpse_queue.sv */
module bmpse_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bmpse_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output bmpse_pkg::entry_t head
);

    bmpse_pkg::entry_t slots_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/bmpse_back.sv */
module bmpse_back
#(
    parameter int unsigned MSG_DEPTH = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  bmpse_pkg::entry_t             head,
    output logic                          pop,
    input  logic                          mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmpse_pkg::DATA_W-1:0]  out_byte,
    output logic                          is_last
);

    localparam int unsigned AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam logic [AW-1:0] CNT_MAX = AW'(MSG_DEPTH - 1);

    logic [bmpse_pkg::DATA_W-1:0] mem [MSG_DEPTH];
    logic [bmpse_pkg::DATA_W-1:0] rdata_reg;

    logic [AW-1:0]                count_reg;
    logic [AW-1:0]                count_next;
    logic [AW-1:0]                rd_idx_reg;
    logic [AW-1:0]                rd_idx_next;
    logic [2:0]                   bit_idx_reg;
    logic [2:0]                   bit_idx_next;
    logic [bmpse_pkg::DATA_W-1:0] char_reg;
    logic [bmpse_pkg::DATA_W-1:0] char_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [bmpse_pkg::DATA_W-1:0] out_byte_reg;
    logic [bmpse_pkg::DATA_W-1:0] out_byte_next;
    logic                         is_last_reg;
    logic                         is_last_next;

    logic                         we;
    logic [bmpse_pkg::DATA_W-1:0] b;
    logic [bmpse_pkg::DATA_W-1:0] char_sel;
    logic [bmpse_pkg::LEN_BITS-1:0] len_bits;
    logic [bmpse_pkg::SLOT_W-1:0] len_idx;
    logic [3:0]                   step;
    logic [3:0]                   bit_sum;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_last   = is_last_reg;

    always_comb
    begin
        pop = head_valid && (head.is_msg || !out_valid_reg || out_ready);

        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        bit_idx_next   = bit_idx_reg;
        char_next      = char_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        is_last_next   = is_last_reg;
        we             = 1'b0;

        len_bits = bmpse_pkg::LEN_BITS'(count_reg);
        len_idx  = head.slot - 4'd1;
        char_sel = (bit_idx_reg == 3'd0) ? rdata_reg : char_reg;
        step     = (bmpse_pkg::mode_t'(mode) == bmpse_pkg::MODE_TWO_BIT) ?
                   bmpse_pkg::STEP_TWO : bmpse_pkg::STEP_ONE;
        bit_sum  = {1'b0, bit_idx_reg} + step;
        b        = head.data;

        if (pop && head.is_msg)
        begin
            if (count_reg < CNT_MAX)
            begin
                we         = 1'b1;
                count_next = count_reg + AW'(1);
            end
        end
        else if (pop)
        begin
            if (head.trailer)
            begin
                if (head.slot == '0)
                begin
                    b[0] = mode;
                end
                else
                begin
                    b[0] = len_bits[len_idx];
                end
            end
            else if (head.embed && rd_idx_reg < count_reg)
            begin
                if (bmpse_pkg::mode_t'(mode) == bmpse_pkg::MODE_TWO_BIT)
                begin
                    b[1:0]    = char_sel[1:0];
                    char_next = {2'b00, char_sel[7:2]};
                end
                else
                begin
                    b[0]      = char_sel[0];
                    char_next = {1'b0, char_sel[7:1]};
                end
                if (bit_sum >= bmpse_pkg::CHAR_BITS)
                begin
                    bit_idx_next = 3'd0;
                    rd_idx_next  = rd_idx_reg + AW'(1);
                end
                else
                begin
                    bit_idx_next = bit_sum[2:0];
                end
            end

            out_valid_next = 1'b1;
            out_byte_next  = b;
            is_last_next   = head.last;

            if (head.last)
            begin
                count_next   = '0;
                rd_idx_next  = '0;
                bit_idx_next = 3'd0;
                char_next    = '0;
            end
        end
    end

    // read port tracks the next read index; a same-cycle write to it is forwarded
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[count_reg] <= head.data;
        end
        if (we && count_reg == rd_idx_next)
        begin
            rdata_reg <= head.data;
        end
        else
        begin
            rdata_reg <= mem[rd_idx_next];
        end
        out_byte_reg <= out_byte_next;
        is_last_reg  <= is_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            bit_idx_reg   <= 3'd0;
            char_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            bit_idx_reg   <= bit_idx_next;
            char_reg      <= char_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/bmp_lsb_stego_embedder_unit.sv */
// BMP LSB embedder. Requests with kind 0 load message bytes (up to MSG_DEPTH-1,
// further loads are dropped); requests with kind 1 stream cover bytes, one
// result per cover byte, in order. Pixel offset comes from header bytes 10..13;
// from there on each message byte fills bit 0 of eight cover bytes (mode 0) or
// bits 1:0 of four (mode 1). Byte file_size-11 carries the mode in bit 0 and
// the last ten bytes carry the message length, LSB first. After the byte flagged
// is_last the position and message restart. One request per cycle is sustained
// while out_ready is high: the front classifies by position, a two-entry queue
// decouples it from the back, which reads the message store through one
// registered read port. Requests pass the queue and the output register. Program
// mode and file_size over APB at 0x0 and 0x4 while the stream is idle.
module bmp_lsb_stego_embedder_unit
#(
    parameter int unsigned MSG_DEPTH = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [bmpse_pkg::DATA_W-1:0]         data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bmpse_pkg::DATA_W-1:0]         out_byte,
    output logic                                 is_last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bmpse_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bmpse_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bmpse_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    logic                         mode_reg;
    logic                         mode_next;
    logic [bmpse_pkg::POS_W-1:0]  file_size_reg;
    logic [bmpse_pkg::POS_W-1:0]  file_size_next;
    logic                         wr_en;
    bmpse_pkg::reg_idx_t          reg_idx;

    logic                         push;
    bmpse_pkg::entry_t            push_entry;
    logic                         q_full;
    logic                         pop;
    logic                         head_valid;
    bmpse_pkg::entry_t            head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = bmpse_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        mode_next      = mode_reg;
        file_size_next = file_size_reg;
        case (reg_idx)
            bmpse_pkg::REG_MODE:
            begin
                prdata = {31'd0, mode_reg};
                if (wr_en)
                begin
                    mode_next = pwdata[0];
                end
            end
            bmpse_pkg::REG_FILE_SIZE:
            begin
                prdata = file_size_reg;
                if (wr_en)
                begin
                    file_size_next = pwdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            file_size_reg <= bmpse_pkg::FILE_SIZE_RST;
        end
        else
        begin
            mode_reg      <= mode_next;
            file_size_reg <= file_size_next;
        end
    end

    bmpse_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .data       (data),
        .file_size  (file_size_reg),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    bmpse_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    bmpse_back
    #(
        .MSG_DEPTH (MSG_DEPTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .mode       (mode_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_last    (is_last)
    );

endmodule
